// File: rtl/tei_pkg.sv
package tei_pkg;

  // Bit positions in mip / mie
  localparam int unsigned BitSw    = 3;
  localparam int unsigned BitTimer = 7;
  localparam int unsigned BitExt   = 11;

  // Bit positions in mstatus
  localparam int unsigned MieBit  = 3;
  localparam int unsigned MpieBit = 7;
  localparam int unsigned MppLsb  = 11;

  // Interrupt cause codes (bit 63 is added on top)
  localparam logic [62:0] CauseSw    = 63'd3;
  localparam logic [62:0] CauseTimer = 63'd7;
  localparam logic [62:0] CauseExt   = 63'd11;

  // Privilege modes
  localparam logic [1:0] PrivU = 2'd0;
  localparam logic [1:0] PrivS = 2'd1;
  localparam logic [1:0] PrivM = 2'd3;

  // Target CSR bank
  localparam logic [1:0] TgtNone = 2'd0;
  localparam logic [1:0] TgtM    = 2'd1;
  localparam logic [1:0] TgtS    = 2'd2;

  // Priority levels in service
  localparam logic [1:0] LvlSw    = 2'd1;
  localparam logic [1:0] LvlTimer = 2'd2;
  localparam logic [1:0] LvlExt   = 2'd3;

  typedef enum logic [1:0] {
    CFG_MTVEC = 2'd0,
    CFG_STVEC = 2'd1,
    CFG_MIE   = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    SRC_NONE,
    SRC_EXC,
    SRC_EXT,
    SRC_TIMER,
    SRC_SW
  } src_e;

  typedef struct packed {
    logic        kind;
    logic [63:0] current_pc;
    logic [63:0] trap_cause;
    logic [1:0]  privilege;
    logic [63:0] status_word;
    logic [11:0] pending_word;
    logic [1:0]  active_level;
    logic        external_claimed;
    logic [63:0] timer_now;
    logic [63:0] timer_compare;
  } req_t;

  typedef struct packed {
    logic        trap_taken;
    logic [1:0]  target_level;
    logic [63:0] next_pc;
    logic [1:0]  next_privilege;
    logic [63:0] next_status;
    logic [11:0] next_pending;
    logic [1:0]  next_level;
    logic [63:0] saved_pc;
    logic [63:0] saved_cause;
    logic        claim_consumed;
  } rsp_t;

  // Request plus the selected trap source, carried from decode to update
  typedef struct packed {
    req_t req;
    src_e src;
  } sel_t;

endpackage

// File: rtl/tei_decode.sv
module tei_decode (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          vld_i,
  input  tei_pkg::req_t req_i,
  input  logic [11:0]   ie_i,
  output logic          vld_o,
  output tei_pkg::sel_t sel_o
);
  import tei_pkg::*;

  logic vld_q;
  sel_t sel_d, sel_q;

  // Pick the trap source: exception, else, if MIE is set, external > timer > software
  always_comb begin
    sel_d.req = req_i;
    if (!req_i.kind) begin
      sel_d.src = SRC_EXC;
    end else if (!req_i.status_word[MieBit]) begin
      sel_d.src = SRC_NONE;
    end else if (ie_i[BitExt] && req_i.pending_word[BitExt] &&
                 (req_i.active_level < LvlExt) && req_i.external_claimed) begin
      sel_d.src = SRC_EXT;
    end else if (ie_i[BitTimer] && (req_i.timer_now >= req_i.timer_compare) &&
                 (req_i.active_level < LvlTimer)) begin
      sel_d.src = SRC_TIMER;
    end else if (ie_i[BitSw] && req_i.pending_word[BitSw] &&
                 (req_i.active_level < LvlSw)) begin
      sel_d.src = SRC_SW;
    end else begin
      sel_d.src = SRC_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    sel_q <= sel_d;
  end

  assign vld_o = vld_q;
  assign sel_o = sel_q;

endmodule

// File: rtl/tei_update.sv
module tei_update (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          vld_i,
  input  tei_pkg::sel_t sel_i,
  input  logic [63:0]   mtvec_i,
  input  logic [63:0]   stvec_i,
  output logic          vld_o,
  output tei_pkg::rsp_t rsp_o
);
  import tei_pkg::*;

  logic        vld_q;
  rsp_t        rsp_d, rsp_q;
  logic [1:0]  priv;
  logic [63:0] st;
  logic [63:0] cause;

  always_comb begin
    priv = (sel_i.req.privilege == 2'd2) ? PrivM : sel_i.req.privilege;
    st   = sel_i.req.status_word;

    case (sel_i.src)
      SRC_EXT:   cause = {1'b1, CauseExt};
      SRC_TIMER: cause = {1'b1, CauseTimer};
      SRC_SW:    cause = {1'b1, CauseSw};
      default:   cause = sel_i.req.trap_cause;
    endcase

    // Pass-through defaults for the no-trap case
    rsp_d.trap_taken     = 1'b0;
    rsp_d.target_level   = TgtNone;
    rsp_d.next_pc        = sel_i.req.current_pc;
    rsp_d.next_privilege = sel_i.req.privilege;
    rsp_d.next_status    = sel_i.req.status_word;
    rsp_d.next_pending   = sel_i.req.pending_word;
    rsp_d.next_level     = sel_i.req.active_level;
    rsp_d.saved_pc       = '0;
    rsp_d.saved_cause    = '0;
    rsp_d.claim_consumed = 1'b0;

    if (sel_i.src != SRC_NONE) begin
      rsp_d.trap_taken  = 1'b1;
      rsp_d.saved_pc    = sel_i.req.current_pc;
      rsp_d.saved_cause = cause;
      if (priv == PrivS) begin
        rsp_d.target_level   = TgtS;
        rsp_d.next_pc        = stvec_i;
        rsp_d.next_privilege = PrivS;
      end else begin
        st[MppLsb +: 2]      = priv;
        st[MpieBit]          = st[MieBit];
        rsp_d.target_level   = TgtM;
        rsp_d.next_pc        = mtvec_i;
        rsp_d.next_privilege = PrivM;
        rsp_d.next_status    = st;
      end
    end

    case (sel_i.src)
      SRC_EXT: begin
        rsp_d.next_pending[BitExt] = 1'b0;
        rsp_d.next_level           = LvlExt;
        rsp_d.claim_consumed       = 1'b1;
      end
      SRC_TIMER: begin
        rsp_d.next_level = LvlTimer;
      end
      SRC_SW: begin
        rsp_d.next_pending[BitSw] = 1'b0;
        rsp_d.next_level          = LvlSw;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign vld_o = vld_q;
  assign rsp_o = rsp_q;

endmodule

// File: rtl/trap_entry_interrupt_select.sv
// Trap entry and interrupt selection for one hart.
//
// Request channel: drive req_i and pulse start_i; a request is taken at every
// rising edge where start_i is high and busy_o is low. busy_o stays low, so a
// new request may be issued every cycle.
// Result channel: done_o is high for exactly one cycle with rsp_o valid; the
// receiver must take it in that cycle, there is no back-pressure.
// Path: a request passes the input register, the source decode register and
// the trap update register before done_o rises with the result.
// Throughput: one request per cycle; the three stages run independently.
// Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i
// (0 mtvec, 1 stvec, 2 mie) at the clock edge; write only while no request
// is in flight. Index 3 is ignored.
// Reset: rst_ni clears all stage valid bits and the configuration registers;
// nothing is in flight afterwards and the block is ready at once.
module trap_entry_interrupt_select (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  tei_pkg::req_t req_i,
  output logic          done_o,
  output tei_pkg::rsp_t rsp_o,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic [63:0]   cfg_wdata_i
);
  import tei_pkg::*;

  // Configuration registers
  logic [63:0] mtvec_q, stvec_q;
  logic [11:0] mie_q;

  // Stage 1: request capture
  logic vld_q;
  req_t req_q;

  // Stage 2 outputs
  logic dec_vld;
  sel_t dec_sel;

  // Never stall: every stage advances every cycle
  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mtvec_q <= '0;
      stvec_q <= '0;
      mie_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MTVEC: mtvec_q <= cfg_wdata_i;
        CFG_STVEC: stvec_q <= cfg_wdata_i;
        CFG_MIE:   mie_q   <= cfg_wdata_i[11:0];
        default: begin
          // unmapped index, drop the write
        end
      endcase
    end
  end

  // Register the request; the valid bit travels with it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= start_i & ~busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_i;
  end

  // Stage 2: timer compare and priority select
  tei_decode u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (vld_q),
    .req_i  (req_q),
    .ie_i   (mie_q),
    .vld_o  (dec_vld),
    .sel_o  (dec_sel)
  );

  // Stage 3: build the CSR updates into the result register
  tei_update u_update (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .vld_i   (dec_vld),
    .sel_i   (dec_sel),
    .mtvec_i (mtvec_q),
    .stvec_i (stvec_q),
    .vld_o   (done_o),
    .rsp_o   (rsp_o)
  );

endmodule
